// ===== hdl/tcn_pkg.sv =====
package tcn_pkg;

	localparam logic OP_COEF   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef enum logic [1:0] {
		LAYER_A = 2'd0,
		LAYER_B = 2'd1,
		LAYER_C = 2'd2
	} layer_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic mac;
	} mac_ctrl_t;

endpackage

// ===== hdl/tcn_mac.sv =====
module tcn_mac #(
	parameter int DATA_WIDTH    = 16,
	parameter int FRACTION_BITS = 8,
	parameter int ACC_WIDTH     = 48
) (
	input  logic                         clk,
	input  tcn_pkg::mac_ctrl_t           ctrl,
	input  logic signed [DATA_WIDTH-1:0] bias,
	input  logic signed [DATA_WIDTH-1:0] weight,
	input  logic signed [DATA_WIDTH-1:0] value,
	input  logic                         relu,
	output logic signed [DATA_WIDTH-1:0] result
);

	localparam logic signed [ACC_WIDTH-1:0] HI =
		ACC_WIDTH'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
	localparam logic signed [ACC_WIDTH-1:0] LO = -HI - ACC_WIDTH'(1);

	logic signed [ACC_WIDTH-1:0]      acc_q;
	logic signed [2*DATA_WIDTH-1:0]   prod;
	logic signed [ACC_WIDTH-1:0]      shifted;

	assign prod = weight * value;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.load) begin
			acc_q <= ACC_WIDTH'(bias) <<< FRACTION_BITS;
		end else if (ctrl.mac) begin
			acc_q <= acc_q + ACC_WIDTH'(prod);
		end
	end

	assign shifted = acc_q >>> FRACTION_BITS;

	always_comb begin
		if (shifted > HI) begin
			result = HI[DATA_WIDTH-1:0];
		end else if (shifted < LO) begin
			result = LO[DATA_WIDTH-1:0];
		end else begin
			result = shifted[DATA_WIDTH-1:0];
		end
		if (relu && result[DATA_WIDTH-1]) begin
			result = '0;
		end
	end

endmodule

// ===== hdl/tcn_dilated_causal_conv.sv =====
// Three-layer dilated causal convolution network over a word stream. A word with
// operation 0 stores coef_value at coef_index in state ST_WR and gives no
// result. A word with operation 1 carries one time step of the input channels
// and gives one network output word. All multiply-accumulates run on a single
// multiplier, one product per cycle. Each output fetches its bias in ST_BIAS,
// runs its products in ST_MAC, then waits in ST_END to drain the read and
// multiply pipeline and finish the sum. ST_IDLE accepts the word and ST_SHFT
// shifts the histories after the network output word is written.
// A new word is taken only when the result register is empty.
module tcn_dilated_causal_conv #(
	parameter int INPUT_CHANNELS  = 4,
	parameter int HIDDEN_CHANNELS = 2,
	parameter int TAPS            = 3,
	parameter int COEF_DEPTH      = 64,
	parameter int DATA_WIDTH      = 16,
	parameter int FRACTION_BITS   = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// operation, coef_index[5:0], coef_value, sample_ch0..3, zero fill
	input  logic [((5*DATA_WIDTH+7+7)/8)*8-1:0] s_tdata,
	// sequence_start
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// network_output
	output logic [DATA_WIDTH-1:0]           m_tdata
);

	localparam int I = INPUT_CHANNELS;
	localparam int H = HIDDEN_CHANNELS;
	localparam int T = TAPS;
	localparam int OFS_WB = I * H * T;
	localparam int OFS_WC = OFS_WB + H * H * T;
	localparam int OFS_BA = OFS_WC + H * T;
	localparam int OFS_BB = OFS_BA + H;
	localparam int OFS_BC = OFS_BB + H;
	localparam int AW = $clog2(COEF_DEPTH);
	localparam int HL = 2 * T - 1;
	localparam int IW = (I > 1) ? $clog2(I) : 1;
	localparam int HW = (H > 1) ? $clog2(H) : 1;
	localparam int TW = (T > 1) ? $clog2(T) : 1;
	localparam int DW = DATA_WIDTH;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BIAS = 3'd1;
	localparam logic [2:0] ST_MAC  = 3'd2;
	localparam logic [2:0] ST_END  = 3'd3;
	localparam logic [2:0] ST_SHFT = 3'd4;
	localparam logic [2:0] ST_WR   = 3'd5;

	logic [2:0] state_q;
	tcn_pkg::layer_t layer_q;
	logic [HW-1:0] o_q;
	logic [IW-1:0] i_q;
	logic [TW-1:0] k_q;
	logic [7:0] addr;

	logic signed [DW-1:0] mem [COEF_DEPTH];
	logic signed [DW-1:0] rd_q;
	logic signed [DW-1:0] x_q [I];
	logic signed [DW-1:0] xh_q [I][T];
	logic signed [DW-1:0] ha_q [H];
	logic signed [DW-1:0] hah_q [H][T];
	logic signed [DW-1:0] hb_q [H];
	logic signed [DW-1:0] hbh_q [H][HL+1];
	logic signed [DW-1:0] value, result;
	logic [5:0] widx_q;
	logic signed [DW-1:0] wval_q;
	tcn_pkg::mac_ctrl_t ctrl;
	logic mac_d_q, load_d_q, relu;

	logic [5:0] in_idx;
	logic signed [DW-1:0] in_val;
	assign in_idx = s_tdata[6:1];
	assign in_val = s_tdata[DW+6:7];

	assign s_tready = (state_q == ST_IDLE) && !m_tvalid;

	always_comb begin
		addr = '0;
		unique case (layer_q)
			tcn_pkg::LAYER_A: addr = (state_q == ST_BIAS) ? 8'(OFS_BA + int'(o_q)) :
				8'((int'(o_q) * I + int'(i_q)) * T + int'(k_q));
			tcn_pkg::LAYER_B: addr = (state_q == ST_BIAS) ? 8'(OFS_BB + int'(o_q)) :
				8'(OFS_WB + (int'(o_q) * H + int'(i_q)) * T + int'(k_q));
			tcn_pkg::LAYER_C: addr = (state_q == ST_BIAS) ? 8'(OFS_BC) :
				8'(OFS_WC + int'(i_q) * T + int'(k_q));
			default: addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WR && int'(widx_q) < COEF_DEPTH) begin
			mem[AW'(widx_q)] <= wval_q;
		end
		if (int'(addr) < COEF_DEPTH) begin
			rd_q <= mem[AW'(addr)];
		end else begin
			rd_q <= '0;
		end
	end

	always_comb begin
		value = '0;
		unique case (layer_q)
			tcn_pkg::LAYER_A: value = (k_q == '0) ? x_q[i_q] : xh_q[i_q][k_q - 1'b1];
			tcn_pkg::LAYER_B: value = (k_q == '0) ? ha_q[i_q[HW-1:0]] :
				hah_q[i_q[HW-1:0]][k_q - 1'b1];
			tcn_pkg::LAYER_C: value = (k_q == '0) ? hb_q[i_q[HW-1:0]] :
				hbh_q[i_q[HW-1:0]][{k_q, 1'b0} - 1'b1];
			default: value = '0;
		endcase
	end

	logic signed [DW-1:0] value_s1;
	always_ff @(posedge clk) value_s1 <= value;

	assign ctrl.clear = 1'b0;
	assign ctrl.load  = load_d_q;
	assign ctrl.mac   = mac_d_q;
	assign relu = (layer_q != tcn_pkg::LAYER_C);

	tcn_mac #(.DATA_WIDTH(DW), .FRACTION_BITS(FRACTION_BITS), .ACC_WIDTH(2*DW+16)) u_mac (
		.clk(clk), .ctrl(ctrl), .bias(rd_q), .weight(rd_q), .value(value_s1),
		.relu(relu), .result(result)
	);

	logic [IW-1:0] i_last;
	assign i_last = (layer_q == tcn_pkg::LAYER_A) ? IW'(I - 1) : IW'(H - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			layer_q <= tcn_pkg::LAYER_A;
			o_q <= '0;
			i_q <= '0;
			k_q <= '0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
			mac_d_q <= 1'b0;
			load_d_q <= 1'b0;
			widx_q <= '0;
			wval_q <= '0;
			for (int c = 0; c < I; c++) x_q[c] <= '0;
			for (int c = 0; c < I; c++) for (int a = 0; a < T; a++) xh_q[c][a] <= '0;
			for (int c = 0; c < H; c++) begin
				ha_q[c] <= '0;
				hb_q[c] <= '0;
				for (int a = 0; a < T; a++) hah_q[c][a] <= '0;
				for (int a = 0; a <= HL; a++) hbh_q[c][a] <= '0;
			end
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			load_d_q <= (state_q == ST_BIAS);
			mac_d_q <= (state_q == ST_MAC);
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						if (s_tdata[0] == tcn_pkg::OP_COEF) begin
							widx_q <= in_idx;
							wval_q <= in_val;
							state_q <= ST_WR;
						end else begin
							for (int c = 0; c < I; c++) x_q[c] <= s_tdata[7+DW*(c+1) +: DW];
							if (s_tuser) begin
								for (int c = 0; c < I; c++)
									for (int a = 0; a < T; a++) xh_q[c][a] <= '0;
								for (int c = 0; c < H; c++) begin
									for (int a = 0; a < T; a++) hah_q[c][a] <= '0;
									for (int a = 0; a <= HL; a++) hbh_q[c][a] <= '0;
								end
							end
							layer_q <= tcn_pkg::LAYER_A;
							o_q <= '0;
							i_q <= '0;
							k_q <= '0;
							state_q <= ST_BIAS;
						end
					end
				end
				ST_WR: state_q <= ST_IDLE;
				ST_BIAS: state_q <= ST_MAC;
				ST_MAC: begin
					if (k_q == TW'(T - 1)) begin
						k_q <= '0;
						if (i_q == i_last) begin
							i_q <= '0;
							state_q <= ST_END;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_END: begin
					if (!mac_d_q) begin
						unique case (layer_q)
							tcn_pkg::LAYER_A: ha_q[o_q] <= result;
							tcn_pkg::LAYER_B: hb_q[o_q] <= result;
							default: m_tdata <= result;
						endcase
						if (layer_q == tcn_pkg::LAYER_C) begin
							m_tvalid <= 1'b1;
							state_q <= ST_SHFT;
						end else if (o_q == HW'(H - 1)) begin
							o_q <= '0;
							layer_q <= (layer_q == tcn_pkg::LAYER_A) ?
								tcn_pkg::LAYER_B : tcn_pkg::LAYER_C;
							state_q <= ST_BIAS;
						end else begin
							o_q <= o_q + 1'b1;
							state_q <= ST_BIAS;
						end
					end
				end
				ST_SHFT: begin
					for (int c = 0; c < I; c++) begin
						for (int a = T - 1; a > 0; a--) xh_q[c][a] <= xh_q[c][a-1];
						xh_q[c][0] <= x_q[c];
					end
					for (int c = 0; c < H; c++) begin
						for (int a = T - 1; a > 0; a--) hah_q[c][a] <= hah_q[c][a-1];
						hah_q[c][0] <= ha_q[c];
						for (int a = HL; a > 0; a--) hbh_q[c][a] <= hbh_q[c][a-1];
						hbh_q[c][0] <= hb_q[c];
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
